/* rtl/max_heap_distance_queue_top_defines.svh */
// ----------------------------------------------------------------------------
// max_heap_distance_queue_top_defines
// Assertion macros used by the heap queue sequencer. They sample on clk_i and are
// disabled while rst_ni is low, so both names must exist where they are used.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_DISTANCE_QUEUE_TOP_DEFINES_SVH
`define MAX_HEAP_DISTANCE_QUEUE_TOP_DEFINES_SVH

// property that must hold at every clock edge
`define MHDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition in one cycle implies a consequence in the next
`define MHDQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/mhdq_pkg.sv */
// ----------------------------------------------------------------------------
// mhdq_pkg
// Shared widths, codes and the result type of the distance heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhdq_pkg;

  // default sizing
  localparam int unsigned HeapDepthDflt = 256;
  localparam int unsigned IndexBitsDflt = 20;

  // fixed field widths of the request and result channels
  localparam int unsigned KeyW = 32;
  localparam int unsigned IdxW = 20;
  localparam int unsigned CntW = 9;
  localparam int unsigned ErrW = 2;

  // command codes
  localparam logic CMD_PUSH    = 1'b0;
  localparam logic CMD_REPLACE = 1'b1;

  // error codes
  localparam logic [ErrW-1:0] ERR_OK    = 2'd0;
  localparam logic [ErrW-1:0] ERR_FULL  = 2'd1;
  localparam logic [ErrW-1:0] ERR_EMPTY = 2'd2;

  // one result as handed from the sequencer to the output stage
  typedef struct packed {
    logic [KeyW-1:0] top_key;
    logic [IdxW-1:0] top_index;
    logic [CntW-1:0] entry_count;
    logic [ErrW-1:0] error_code;
  } res_t;

endpackage

`default_nettype wire

/* rtl/mhdq_in_if.sv */
// ----------------------------------------------------------------------------
// mhdq_in_if
// Request channel: push or replace-top command with key and record index.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhdq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [mhdq_pkg::KeyW-1:0]   new_key;
  logic [mhdq_pkg::IdxW-1:0]   new_index;

  modport source (output valid, output command, output new_key, output new_index,
                  input ready);
  modport sink (input valid, input command, input new_key, input new_index,
                output ready);
endinterface

`default_nettype wire

/* rtl/mhdq_out_if.sv */
// ----------------------------------------------------------------------------
// mhdq_out_if
// Result channel: top entry, entry count and error code after each request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhdq_out_if;
  logic                        valid;
  logic                        ready;
  logic [mhdq_pkg::KeyW-1:0]   top_key;
  logic [mhdq_pkg::IdxW-1:0]   top_index;
  logic [mhdq_pkg::CntW-1:0]   entry_count;
  logic [mhdq_pkg::ErrW-1:0]   error_code;

  modport source (output valid, output top_key, output top_index, output entry_count,
                  output error_code, input ready);
  modport sink (input valid, input top_key, input top_index, input entry_count,
                input error_code, output ready);
endinterface

`default_nettype wire

/* rtl/mhdq_mem.sv */
// ----------------------------------------------------------------------------
// mhdq_mem
// Heap entry store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mhdq_mem #(
  parameter int unsigned DEPTH = mhdq_pkg::HeapDepthDflt,
  parameter int unsigned WIDTH = mhdq_pkg::KeyW + mhdq_pkg::IndexBitsDflt
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_a_q;
  logic [WIDTH-1:0] rd_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports, loaded while re_i is high
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_a_q <= mem_q[raddr_a_i];
      rd_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

`default_nettype wire

/* rtl/mhdq_ctrl.sv */
// ----------------------------------------------------------------------------
// mhdq_ctrl
// Sift sequencer: walks the heap one level per read and compare state pair,
// reading parent or children from the entry store and writing the displaced
// entry back.
`default_nettype none
`include "max_heap_distance_queue_top_defines.svh"

module mhdq_ctrl #(
  parameter int unsigned HEAP_DEPTH = mhdq_pkg::HeapDepthDflt,
  parameter int unsigned INDEX_BITS = mhdq_pkg::IndexBitsDflt
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  // request side
  input  wire logic                                     in_valid_i,
  output logic                                          in_ready_o,
  input  wire logic                                     command_i,
  input  wire logic [mhdq_pkg::KeyW-1:0]                new_key_i,
  input  wire logic [mhdq_pkg::IdxW-1:0]                new_index_i,
  // result side
  output logic                                          res_valid_o,
  input  wire logic                                     res_ready_i,
  output mhdq_pkg::res_t                                res_o,
  // entry store
  output logic                                          mem_we_o,
  output logic [$clog2(HEAP_DEPTH)-1:0]                 mem_waddr_o,
  output logic [mhdq_pkg::KeyW+INDEX_BITS-1:0]          mem_wdata_o,
  output logic                                          mem_re_o,
  output logic [$clog2(HEAP_DEPTH)-1:0]                 mem_raddr_a_o,
  output logic [$clog2(HEAP_DEPTH)-1:0]                 mem_raddr_b_o,
  input  wire logic [mhdq_pkg::KeyW+INDEX_BITS-1:0]     mem_rdata_a_i,
  input  wire logic [mhdq_pkg::KeyW+INDEX_BITS-1:0]     mem_rdata_b_i
);
  import mhdq_pkg::*;

  localparam int unsigned AddrW = $clog2(HEAP_DEPTH);
  localparam int unsigned CntIW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned ChW   = AddrW + 2;
  localparam int unsigned EntW  = KeyW + INDEX_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_UPC  = 3'd2;
  localparam logic [2:0] S_DN   = 3'd3;
  localparam logic [2:0] S_DNC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CntIW-1:0] count_q, count_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [EntW-1:0]  cur_q, cur_d;
  logic [EntW-1:0]  root_q, root_d;
  logic [ErrW-1:0]  err_q, err_d;
  logic             rvld_q, rvld_d;

  logic [ChW-1:0]   lc, rc, cnt_ext;
  logic             l_ok, r_ok, full;
  logic [AddrW-1:0] parent, l_addr, r_addr;
  logic [KeyW-1:0]  a_key, b_key, cur_key, best_key;
  logic             take_l, take_r;
  logic [EntW-1:0]  entry_in;

  // neighbour addresses of the current position
  assign lc      = {1'b0, pos_q, 1'b1};
  assign rc      = lc + ChW'(1);
  assign cnt_ext = ChW'(count_q);
  assign l_ok    = lc < cnt_ext;
  assign r_ok    = rc < cnt_ext;
  assign l_addr  = lc[AddrW-1:0];
  assign r_addr  = rc[AddrW-1:0];
  assign parent  = (pos_q - AddrW'(1)) >> 1;
  assign full    = count_q == CntIW'(HEAP_DEPTH);

  // key compares: left child wins only when strictly greater, right only when
  // strictly greater than the winner so far
  assign a_key    = mem_rdata_a_i[EntW-1 -: KeyW];
  assign b_key    = mem_rdata_b_i[EntW-1 -: KeyW];
  assign cur_key  = cur_q[EntW-1 -: KeyW];
  assign take_l   = a_key > cur_key;
  assign best_key = take_l ? a_key : cur_key;
  assign take_r   = rvld_q && (b_key > best_key);

  assign entry_in = {new_key_i, INDEX_BITS'(new_index_i)};

  // sequencer
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    pos_d         = pos_q;
    cur_d         = cur_q;
    err_d         = err_q;
    rvld_d        = rvld_q;
    in_ready_o    = 1'b0;
    res_valid_o   = 1'b0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = cur_q;
    mem_re_o      = 1'b0;
    mem_raddr_a_o = l_addr;
    mem_raddr_b_o = r_addr;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          err_d = ERR_OK;
          cur_d = entry_in;
          if (command_i == CMD_PUSH) begin
            if (full) begin
              err_d   = ERR_FULL;
              state_d = S_FIN;
            end else begin
              pos_d   = AddrW'(count_q);
              count_d = count_q + CntIW'(1);
              state_d = S_UP;
            end
          end else begin
            if (count_q == '0) begin
              err_d   = ERR_EMPTY;
              state_d = S_FIN;
            end else begin
              pos_d   = '0;
              state_d = S_DN;
            end
          end
        end
      end
      S_UP: begin
        if (pos_q == '0) begin
          mem_we_o = 1'b1;
          state_d  = S_FIN;
        end else begin
          mem_re_o      = 1'b1;
          mem_raddr_a_o = parent;
          state_d       = S_UPC;
        end
      end
      S_UPC: begin
        mem_we_o = 1'b1;
        if (a_key >= cur_key) begin
          state_d = S_FIN;
        end else begin
          mem_wdata_o = mem_rdata_a_i;
          pos_d       = parent;
          state_d     = S_UP;
        end
      end
      S_DN: begin
        if (!l_ok) begin
          mem_we_o = 1'b1;
          state_d  = S_FIN;
        end else begin
          mem_re_o = 1'b1;
          rvld_d   = r_ok;
          state_d  = S_DNC;
        end
      end
      S_DNC: begin
        mem_we_o = 1'b1;
        if (take_r) begin
          mem_wdata_o = mem_rdata_b_i;
          pos_d       = r_addr;
          state_d     = S_DN;
        end else if (take_l) begin
          mem_wdata_o = mem_rdata_a_i;
          pos_d       = l_addr;
          state_d     = S_DN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // shadow copy of the root, kept in step with every write to entry zero
  always_comb begin
    root_d = root_q;
    if (mem_we_o && (mem_waddr_o == '0)) begin
      root_d = mem_wdata_o;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      err_q   <= ERR_OK;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      err_q   <= err_d;
      rvld_q  <= rvld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    cur_q  <= cur_d;
    root_q <= root_d;
  end

  // result; an empty heap reports a zero top
  always_comb begin
    res_o.top_key     = (count_q != '0) ? root_q[EntW-1 -: KeyW] : '0;
    res_o.top_index   = (count_q != '0) ? IdxW'(root_q[INDEX_BITS-1:0]) : '0;
    res_o.entry_count = CntW'(count_q);
    res_o.error_code  = err_q;
  end

  // checks
  `MHDQ_ASSERT(a_count_range, count_q <= CntIW'(HEAP_DEPTH), "entry count beyond heap depth")
  `MHDQ_ASSERT(a_write_in_sift,
    !mem_we_o || state_q == S_UP || state_q == S_UPC || state_q == S_DN || state_q == S_DNC,
    "entry store written outside a sift")
  `MHDQ_ASSERT_NEXT(a_full_dropped,
    in_valid_i && in_ready_o && command_i == CMD_PUSH && full,
    count_q == $past(count_q) && err_q == ERR_FULL && state_q == S_FIN,
    "push on full heap not dropped")
  `MHDQ_ASSERT_NEXT(a_empty_dropped,
    in_valid_i && in_ready_o && command_i == CMD_REPLACE && count_q == '0,
    count_q == '0 && err_q == ERR_EMPTY && state_q == S_FIN,
    "replace on empty heap not dropped")

endmodule

`default_nettype wire

/* rtl/max_heap_distance_queue_top.sv */
// ----------------------------------------------------------------------------
// max_heap_distance_queue_top
// Binary max-heap of (distance key, record index) entries with push and
// replace-top requests; one result per request carries top, count and error.
// Requests are handled one at a time: the next is taken in the cycle after
// the result loads into the output register, so result stalls hold requests.
// Dropped requests (push on full, replace on empty) go straight to the result
// state without touching the heap.
// Reset empties the heap at once; stored entries are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_distance_queue_top #(
  parameter int unsigned HEAP_DEPTH = mhdq_pkg::HeapDepthDflt,
  parameter int unsigned INDEX_BITS = mhdq_pkg::IndexBitsDflt
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mhdq_in_if.sink     cmd_i,
  mhdq_out_if.source  res_o
);
  import mhdq_pkg::*;

  localparam int unsigned AddrW = $clog2(HEAP_DEPTH);
  localparam int unsigned EntW  = KeyW + INDEX_BITS;

  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [EntW-1:0]  mem_wdata, mem_rdata_a, mem_rdata_b;
  logic             res_valid, res_ready;
  res_t             res;
  res_t             out_q;
  logic             out_valid_q;

  // entry store
  mhdq_mem #(
    .DEPTH (HEAP_DEPTH),
    .WIDTH (EntW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  // sift sequencer
  mhdq_ctrl #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (cmd_i.valid),
    .in_ready_o    (cmd_i.ready),
    .command_i     (cmd_i.command),
    .new_key_i     (cmd_i.new_key),
    .new_index_i   (cmd_i.new_index),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  // output register, refilled in the cycle it is taken
  assign res_ready = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.top_key     = out_q.top_key;
  assign res_o.top_index   = out_q.top_index;
  assign res_o.entry_count = out_q.entry_count;
  assign res_o.error_code  = out_q.error_code;

endmodule

`default_nettype wire
